// ===== rtl/small_matrix_multiply_top_assert.svh =====
// Assertion macros for the small matrix multiplier.
// Depends on clk_i and rst_ni being visible in the module that includes it.
`ifndef SMALL_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SMALL_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smm_pkg.sv =====
// Shared constants and codes for the small matrix multiplier.
// No dependencies.
package smm_pkg;

  // Matrix geometry and fixed-point format
  localparam int DIM        = 4;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_LIMIT = (DIM < 4) ? DIM : 4;

  // Field widths
  localparam int IDX_W  = 2;
  localparam int SZ_W   = 3;
  localparam int VAL_W  = 32;
  localparam int MODE_W = 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ADDR_W = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_W = ((IDX_W + IDX_W + VAL_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((IDX_W + IDX_W + VAL_W + 7) / 8) * 8;

  // Rounding offset: half an LSB of the result
  localparam logic signed [ACC_W-1:0] ROUND_HALF = (ACC_W'(1) << FRAC_BITS) >> 1;

  // Input item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A    = 2'd0,
    MODE_WR_B    = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/small_matrix_multiply_top.sv =====
// Small signed fixed-point matrix multiplier: element stores, sequencer, MAC unit.
// Depends on smm_pkg and small_matrix_multiply_top_assert.svh.
//
// Element writes (mode 0 for A, 1 for B) are taken only while idle. A compute beat
// (mode 2) streams out rows_a x cols_b product elements in row-major order, the
// last one with tlast. All products go through one 32x32 multiplier, one
// multiply-accumulate per cycle while the sequencer issues, and each product
// element passes the store read, multiply and accumulate stages, then round
// and saturate, and waits for the output register to be free. s_axis_tready
// stays low until the last element is loaded into the output register. Sizes
// outside 1..4 are clamped; writes past the store and mode 3 are dropped
// without a result.
module small_matrix_multiply_top
  import smm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [SZ_W-1:0]     cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // row[1:0], col[3:2], element_value[35:4]
  input  logic [MODE_W-1:0]   s_axis_tuser,  // mode[1:0]
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // out_row[1:0], out_col[3:2], product_value[35:4]
  output logic                m_axis_tuser,  // saturated[0]
  output logic                m_axis_tlast
);

`include "small_matrix_multiply_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_e;

  // Clamp a size register to 1..SIZE_LIMIT
  function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v);
    logic [SZ_W-1:0] res;
    res = v;
    if (v == '0) res = SZ_W'(1);
    else if (v > SZ_W'(SIZE_LIMIT)) res = SZ_W'(SIZE_LIMIT);
    return res;
  endfunction

  // Input beat fields
  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_val;
  logic             in_beat;
  assign in_row  = s_axis_tdata[IDX_W-1:0];
  assign in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val  = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  logic [SZ_W-1:0] rows_a_q, inner_size_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= SZ_W'(4);
      inner_size_q <= SZ_W'(4);
      cols_b_q     <= SZ_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_ROWS_A:     rows_a_q     <= cfg_data_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        CFG_COLS_B:     cols_b_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer registers
  state_e           state_q;
  logic [SZ_W-1:0]  nr_q, nk_q, nc_q;
  logic [IDX_W-1:0] r_q, c_q, k_q;
  logic             rd_vld_q, rd_last_q;
  logic             prod_vld_q, prod_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic             m_valid_q, m_sat_q, m_last_q;
  logic [M_DATA_W-1:0] m_data_q;

  // Store write decode
  logic wr_in_range, wr_a, wr_b;
  logic [ADDR_W-1:0] wr_addr;
  assign wr_in_range = (int'(in_row) < DIM) && (int'(in_col) < DIM);
  assign wr_a    = in_beat && wr_in_range && (mode_e'(s_axis_tuser) == MODE_WR_A);
  assign wr_b    = in_beat && wr_in_range && (mode_e'(s_axis_tuser) == MODE_WR_B);
  assign wr_addr = ADDR_W'(int'(in_row) * DIM + int'(in_col));

  // Store read addresses: A[r][k], B[k][c]
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  assign rd_addr_a = ADDR_W'(int'(r_q) * DIM + int'(k_q));
  assign rd_addr_b = ADDR_W'(int'(k_q) * DIM + int'(c_q));

  // Element stores with per-entry valid bits; an unwritten entry reads as zero
  logic [VAL_W-1:0]     mem_a [DIM*DIM];
  logic [VAL_W-1:0]     mem_b [DIM*DIM];
  logic [DIM*DIM-1:0]   a_vld_q, b_vld_q;
  logic [VAL_W-1:0]     a_rd_q, b_rd_q;
  logic                 a_ok_q, b_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a[wr_addr] <= in_val;
    if (wr_b) mem_b[wr_addr] <= in_val;
    a_rd_q <= mem_a[rd_addr_a];
    b_rd_q <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      b_vld_q <= '0;
      a_ok_q  <= 1'b0;
      b_ok_q  <= 1'b0;
    end else begin
      if (wr_a) a_vld_q[wr_addr] <= 1'b1;
      if (wr_b) b_vld_q[wr_addr] <= 1'b1;
      a_ok_q <= a_vld_q[rd_addr_a];
      b_ok_q <= b_vld_q[rd_addr_b];
    end
  end

  logic signed [VAL_W-1:0] a_op, b_op;
  assign a_op = a_ok_q ? signed'(a_rd_q) : '0;
  assign b_op = b_ok_q ? signed'(b_rd_q) : '0;

  // Round was folded into the accumulator start value; shift and saturate here
  logic signed [ACC_W-1:0] sh;
  logic                    fits, out_free;
  logic [VAL_W-1:0]        res_val;
  assign sh       = acc_q >>> FRAC_BITS;
  assign fits     = (&sh[ACC_W-1:VAL_W-1]) || !(|sh[ACC_W-1:VAL_W-1]);
  assign res_val  = fits ? sh[VAL_W-1:0]
                  : (sh[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});
  assign out_free = !m_valid_q || m_axis_tready;

  logic k_last, c_last, r_last;
  assign k_last = (k_q == IDX_W'(nk_q - SZ_W'(1)));
  assign c_last = (c_q == IDX_W'(nc_q - SZ_W'(1)));
  assign r_last = (r_q == IDX_W'(nr_q - SZ_W'(1)));

  // Sequencer, MAC pipeline and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nr_q        <= SZ_W'(1);
      nk_q        <= SZ_W'(1);
      nc_q        <= SZ_W'(1);
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      m_valid_q   <= 1'b0;
      m_sat_q     <= 1'b0;
      m_last_q    <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // output beat taken
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      // multiply stage
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= rd_vld_q;
      prod_last_q <= rd_last_q;
      if (rd_vld_q) prod_q <= a_op * b_op;

      // accumulate stage
      if (prod_vld_q) acc_q <= acc_q + ACC_W'(prod_q);

      case (state_q)
        S_IDLE: begin
          if (in_beat && mode_e'(s_axis_tuser) == MODE_COMPUTE) begin
            nr_q    <= eff_size(rows_a_q);
            nk_q    <= eff_size(inner_size_q);
            nc_q    <= eff_size(cols_b_q);
            r_q     <= '0;
            c_q     <= '0;
            k_q     <= '0;
            acc_q   <= ROUND_HALF;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_vld_q  <= 1'b1;
          rd_last_q <= k_last;
          k_q       <= k_q + IDX_W'(1);
          if (k_last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (prod_vld_q && prod_last_q) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_sat_q   <= !fits;
            m_last_q  <= r_last && c_last;
            m_data_q  <= M_DATA_W'({res_val, c_q, r_q});
            k_q       <= '0;
            acc_q     <= ROUND_HALF;
            if (c_last) begin
              c_q <= '0;
              r_q <= r_q + IDX_W'(1);
            end else begin
              c_q <= c_q + IDX_W'(1);
            end
            state_q <= (r_last && c_last) ? S_IDLE : S_ISSUE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;
  assign m_axis_tlast  = m_last_q;

  // MAC pipeline only carries work while a product element is in flight
  `SMM_ASSERT_NOW(a_mac_busy, prod_vld_q, (state_q == S_ISSUE || state_q == S_DRAIN), "product outside compute")
  // inner index never passes the clamped inner size
  `SMM_ASSERT_NOW(a_k_range, state_q == S_ISSUE, (SZ_W'(k_q) < nk_q), "inner index out of range")
  // pipeline is empty whenever a new beat can be taken
  `SMM_ASSERT_NOW(a_idle_empty, s_axis_tready, (!rd_vld_q && !prod_vld_q), "pipeline busy while idle")
  // the final element of a product returns the block to idle
  `SMM_ASSERT_NEXT(a_last_idle, state_q == S_EMIT && out_free && r_last && c_last, (state_q == S_IDLE && m_axis_tlast), "last element without return to idle")

endmodule
